>>> hdl/rv32i_pkg.sv
// Shared opcodes, field codes and helper types for the instruction execute unit.
package rv32i_pkg;

  localparam int DataWordsDefault = 512;

  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JALR   = 7'h67;

  localparam logic [6:0] F7_ZERO = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [31:0] JALR_MASK = 32'hFFFF_FFFE;

  // Write-back request handed from the execute stage to the register file
  typedef struct packed {
    logic        en;
    logic [4:0]  idx;
    logic [31:0] value;
  } rf_write_t;

endpackage

>>> hdl/rv32i_regfile.sv
// 32 x 32 register file with registered reads, write forwarding and valid bits cleared at reset.
module rv32i_regfile (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_en,
  input  logic [4:0]            rs1,
  input  logic [4:0]            rs2,
  input  rv32i_pkg::rf_write_t  wr,
  output logic [31:0]           a,
  output logic [31:0]           b
);

  logic [31:0] mem [32];
  logic [31:0] a_raw;
  logic [31:0] b_raw;

  // Valid bits: an entry not yet written since reset reads as zero
  logic [31:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr.en) begin
      vld[wr.idx] <= 1'b1;
    end
  end

  // Write port, and read ports with forwarding of a same-cycle write
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.value;
    end
    if (rd_en) begin
      if (wr.en && wr.idx == rs1) a_raw <= wr.value;
      else if (vld[rs1] && !(rst)) a_raw <= mem[rs1];
      else a_raw <= '0;
      if (wr.en && wr.idx == rs2) b_raw <= wr.value;
      else if (vld[rs2] && !(rst)) b_raw <= mem[rs2];
      else b_raw <= '0;
    end
  end

  assign a = a_raw;
  assign b = b_raw;

endmodule

>>> hdl/rv32i_dmem.sv
// Word-wide data memory with registered read, write-back port and clear sweep.
module rv32i_dmem #(
  parameter int DATA_WORDS = rv32i_pkg::DataWordsDefault,
  localparam int AW = $clog2(DATA_WORDS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  output logic          busy
);

  logic [31:0] mem [DATA_WORDS];
  logic [AW:0] clr_cnt;

  // Clearing pass after reset, one word a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (busy) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end
  assign busy = (clr_cnt != (AW+1)'(DATA_WORDS));

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_cnt[AW-1:0]] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/rv32i_instruction_execute_unit.sv
// Top level of the single-instruction execute unit.
// Channels: s_axis carries one instruction item, tdata = {pc, instruction}
// (instruction in bits 31:0, pc in 63:32). m_axis returns one result item per
// instruction, tdata = {reg_write_value, reg_write_index, reg_write_enable,
// next_pc} (next_pc in the lowest bits), tuser = illegal.
// Sequence: an item passes through these steps in order: reading the register
// file, reading the data memory word at rs1+imm, and executing with write back
// to both stores. The result is then held in the output register. The next item
// is accepted only once the output register has been emptied, so the block does
// not take a new instruction before the last result has been taken.
// Reset: the register file is cleared at once through valid bits; the data
// memory is swept to zero, during which s_axis_tready is low. When
// m_axis_tready is low the result holds in the output register and no new
// item starts until it is taken.
module rv32i_instruction_execute_unit #(
  parameter int DATA_WORDS = rv32i_pkg::DataWordsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // instruction[31:0], pc[63:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // next_pc[31:0], enable[32], index[37:33],
                                      // value[69:38], zero fill[71:70]
  output logic        m_axis_tuser    // illegal
);

  localparam int AW = $clog2(DATA_WORDS);
  localparam logic [1:0] ST_IDLE = 2'd0, ST_RF = 2'd1, ST_MEM = 2'd2;

  logic [1:0]  state;
  logic [31:0] ins;
  logic [31:0] pc;
  logic [31:0] a, b;
  logic [31:0] w;
  logic        clr_busy;
  logic        out_full;
  rv32i_pkg::rf_write_t wb;
  logic        st_en;
  logic [AW-1:0] st_addr;
  logic [31:0] st_data;

  // Decode fields
  logic [6:0] op, f7;
  logic [2:0] f3;
  logic [4:0] dst, rs1, rs2;
  logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u;
  assign op  = ins[6:0];
  assign dst = ins[11:7];
  assign f3  = ins[14:12];
  assign rs1 = ins[19:15];
  assign rs2 = ins[24:20];
  assign f7  = ins[31:25];
  assign imm_i = {{20{ins[31]}}, ins[31:20]};
  assign imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
  assign imm_b = {{20{ins[31]}}, ins[7], ins[30:25], ins[11:8], 1'b0};
  assign imm_j = {{12{ins[31]}}, ins[19:12], ins[20], ins[30:21], 1'b0};
  assign imm_u = {ins[31:12], 12'h000};

  logic accept;
  assign s_axis_tready = (state == ST_IDLE) && !out_full && !clr_busy;
  assign accept = s_axis_tvalid && s_axis_tready;

  // Sequencer: read registers, read memory, execute
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: if (accept) state <= ST_RF;
        ST_RF:   state <= ST_MEM;
        ST_MEM:  state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ins <= s_axis_tdata[31:0];
      pc  <= s_axis_tdata[63:32];
    end
  end

  rv32i_regfile u_rf (
    .clk(clk), .rst(rst),
    .rd_en(accept),
    .rs1(s_axis_tdata[19:15]), .rs2(s_axis_tdata[24:20]),
    .wr(wb), .a(a), .b(b)
  );

  // Memory address from rs1 plus load or store offset
  logic [31:0] maddr;
  assign maddr = a + ((op == rv32i_pkg::OPC_STORE) ? imm_s : imm_i);

  rv32i_dmem #(.DATA_WORDS(DATA_WORDS)) u_mem (
    .clk(clk), .rst(rst),
    .rd_en(state == ST_RF), .rd_addr(maddr[AW-1:0]), .rd_data(w),
    .wr_en(st_en), .wr_addr(st_addr), .wr_data(st_data),
    .busy(clr_busy)
  );

  // ALU
  logic        shf;
  logic [31:0] opb;
  logic [4:0]  sh;
  logic        lts;
  logic [31:0] alu_v;
  logic        alu_bad;
  logic        reg_form;
  logic [6:0]  f7e;
  assign reg_form = (op == rv32i_pkg::OPC_OP);
  assign shf = (f3 == 3'd1) || (f3 == 3'd5);
  assign opb = reg_form ? b : (shf ? {27'd0, rs2} : imm_i);
  assign f7e = (reg_form || shf) ? f7 : rv32i_pkg::F7_ZERO;
  assign sh  = opb[4:0];
  assign lts = $signed(a) < $signed(opb);

  always_comb begin
    alu_v = '0;
    alu_bad = 1'b0;
    case (f3)
      3'd0: begin
        if (!reg_form || f7e == rv32i_pkg::F7_ZERO) alu_v = a + opb;
        else if (f7e == rv32i_pkg::F7_ALT) alu_v = a - opb;
        else alu_bad = 1'b1;
      end
      3'd1: begin
        if (f7e == rv32i_pkg::F7_ZERO) alu_v = a << sh;
        else alu_bad = 1'b1;
      end
      3'd5: begin
        if (f7e == rv32i_pkg::F7_ZERO) alu_v = a >> sh;
        else if (f7e == rv32i_pkg::F7_ALT) alu_v = $unsigned($signed(a) >>> sh);
        else alu_bad = 1'b1;
      end
      default: begin
        if (f7e != rv32i_pkg::F7_ZERO) alu_bad = 1'b1;
        else begin
          case (f3)
            3'd2: alu_v = {31'd0, lts};
            3'd3: alu_v = {31'd0, a < opb};
            3'd4: alu_v = a ^ opb;
            3'd6: alu_v = a | opb;
            default: alu_v = a & opb;
          endcase
        end
      end
    endcase
  end

  // Execute
  logic [31:0] val, nxt, pc4;
  logic writes, bad, take;
  assign pc4 = pc + 32'd4;

  always_comb begin
    val = '0; nxt = pc4; writes = 1'b0; bad = 1'b0; take = 1'b0;
    st_data = w; st_en = 1'b0;
    case (op)
      rv32i_pkg::OPC_OP, rv32i_pkg::OPC_OPIMM: begin
        val = alu_v; bad = alu_bad; writes = 1'b1;
      end
      rv32i_pkg::OPC_LUI:   begin val = imm_u; writes = 1'b1; end
      rv32i_pkg::OPC_AUIPC: begin val = pc + imm_u; writes = 1'b1; end
      rv32i_pkg::OPC_JAL:   begin val = pc4; nxt = pc + imm_j; writes = 1'b1; end
      rv32i_pkg::OPC_JALR: begin
        if (f3 != 3'd0) bad = 1'b1;
        else begin
          val = pc4; nxt = (a + imm_i) & rv32i_pkg::JALR_MASK; writes = 1'b1;
        end
      end
      rv32i_pkg::OPC_BRANCH: begin
        case (f3)
          3'd0: take = (a == b);
          3'd1: take = (a != b);
          3'd4: take = $signed(a) < $signed(b);
          3'd5: take = !($signed(a) < $signed(b));
          3'd6: take = a < b;
          3'd7: take = a >= b;
          default: bad = 1'b1;
        endcase
        if (take) nxt = pc + imm_b;
      end
      rv32i_pkg::OPC_LOAD: begin
        writes = 1'b1;
        case (f3)
          3'd0: val = {{24{w[7]}}, w[7:0]};
          3'd1: val = {{16{w[15]}}, w[15:0]};
          3'd2: val = w;
          3'd4: val = {24'd0, w[7:0]};
          3'd5: val = {16'd0, w[15:0]};
          default: bad = 1'b1;
        endcase
      end
      rv32i_pkg::OPC_STORE: begin
        case (f3)
          3'd0: st_data = {w[31:8], b[7:0]};
          3'd1: st_data = {w[31:16], b[15:0]};
          3'd2: st_data = b;
          default: bad = 1'b1;
        endcase
        st_en = (state == ST_MEM) && !bad;
      end
      default: bad = 1'b1;
    endcase
    if (bad) begin
      nxt = pc4; writes = 1'b0;
    end
    if (dst == 5'd0) writes = 1'b0;
  end

  // Store address held from the read cycle
  always_ff @(posedge clk) begin
    if (state == ST_RF) st_addr <= maddr[AW-1:0];
  end

  assign wb.en    = (state == ST_MEM) && writes;
  assign wb.idx   = dst;
  assign wb.value = val;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (state == ST_MEM) begin
      out_full <= 1'b1;
    end else if (m_axis_tready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_MEM) begin
      m_axis_tdata <= {2'b00, writes ? val : 32'd0, writes ? dst : 5'd0, writes, nxt};
      m_axis_tuser <= bad;
    end
  end
  assign m_axis_tvalid = out_full;

  // Assertions
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !s_axis_tready) else $error("item accepted during clear");
  a_seq: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_RF ##1 state == ST_MEM) else $error("sequence broken");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_full && !m_axis_tready |=> out_full && $stable(m_axis_tdata))
    else $error("result lost");
  a_no_x0: assert property (@(posedge clk) disable iff (rst)
    wb.en |-> wb.idx != 5'd0) else $error("x0 written");

endmodule

>>> tb/tb_rv32i_instruction_execute_unit.sv
// Testbench for the RV32I instruction execute unit: random and directed programs, scoreboard check.
`timescale 1ns / 100ps

module tb_rv32i_instruction_execute_unit;

  localparam int DataWords = rv32i_pkg::DataWordsDefault;
  localparam int WatchdogLimit = 20000;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        wr_en;
    logic [4:0]  wr_idx;
    logic [31:0] wr_val;
    logic        illegal;
  } exec_result_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tuser;

  // Shadow architectural state
  logic [31:0] shadow_regs [32];
  logic [31:0] shadow_mem [DataWords];
  exec_result_t pending_results [$];

  int  fail_count;
  int  send_idle_pct;
  int  recv_stall_pct;
  int  hold_off_cycles;
  int  idle_count;

  rv32i_instruction_execute_unit #(.DATA_WORDS(DataWords)) DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] sign_ext(logic [31:0] v, int bits);
    logic [31:0] m;
    m = 32'd1 << (bits - 1);
    v = v & ((m << 1) - 32'd1);
    return (v ^ m) - m;
  endfunction

  function automatic logic signed_lt(logic [31:0] a, logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  // Compute one instruction on the shadow state; returns its result
  function automatic exec_result_t execute_instruction(logic [31:0] ins, logic [31:0] pc);
    exec_result_t r;
    logic [6:0]  op;
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] a, b, imm_i, imm_s, imm_b, imm_j, imm_u, nxt, val, opb, w;
    logic        writes, bad, take, reg_form;
    int          idx;
    op = ins[6:0]; rd = ins[11:7]; f3 = ins[14:12]; rs1 = ins[19:15];
    rs2 = ins[24:20]; f7 = ins[31:25];
    a = shadow_regs[rs1]; b = shadow_regs[rs2];
    imm_i = sign_ext({20'd0, ins[31:20]}, 12);
    imm_s = sign_ext({20'd0, ins[31:25], ins[11:7]}, 12);
    imm_b = sign_ext({19'd0, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0}, 13);
    imm_j = sign_ext({11'd0, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0}, 21);
    imm_u = {ins[31:12], 12'd0};
    nxt = pc + 32'd4; val = '0; writes = 1'b0; bad = 1'b0;
    case (op)
      rv32i_pkg::OPC_OP, rv32i_pkg::OPC_OPIMM: begin
        reg_form = (op == rv32i_pkg::OPC_OP);
        writes = 1'b1;
        if (reg_form) opb = b;
        else if (f3 == 3'd1 || f3 == 3'd5) opb = {27'd0, rs2};
        else opb = imm_i;
        if (!reg_form && !(f3 == 3'd1 || f3 == 3'd5)) f7 = rv32i_pkg::F7_ZERO;
        case (f3)
          3'd0: begin
            if (!reg_form || f7 == rv32i_pkg::F7_ZERO) val = a + opb;
            else if (f7 == rv32i_pkg::F7_ALT) val = a - opb;
            else bad = 1'b1;
          end
          3'd1: if (f7 == rv32i_pkg::F7_ZERO) val = a << opb[4:0]; else bad = 1'b1;
          3'd5: begin
            if (f7 == rv32i_pkg::F7_ZERO) val = a >> opb[4:0];
            else if (f7 == rv32i_pkg::F7_ALT) val = $signed(a) >>> opb[4:0];
            else bad = 1'b1;
          end
          default: begin
            if (f7 != rv32i_pkg::F7_ZERO) bad = 1'b1;
            else case (f3)
              3'd2: val = {31'd0, signed_lt(a, opb)};
              3'd3: val = {31'd0, a < opb};
              3'd4: val = a ^ opb;
              3'd6: val = a | opb;
              default: val = a & opb;
            endcase
          end
        endcase
      end
      rv32i_pkg::OPC_LUI: begin val = imm_u; writes = 1'b1; end
      rv32i_pkg::OPC_AUIPC: begin val = pc + imm_u; writes = 1'b1; end
      rv32i_pkg::OPC_JAL: begin val = pc + 32'd4; nxt = pc + imm_j; writes = 1'b1; end
      rv32i_pkg::OPC_JALR: begin
        if (f3 != 3'd0) bad = 1'b1;
        else begin
          val = pc + 32'd4; nxt = (a + imm_i) & rv32i_pkg::JALR_MASK; writes = 1'b1;
        end
      end
      rv32i_pkg::OPC_BRANCH: begin
        take = 1'b0;
        case (f3)
          3'd0: take = (a == b);
          3'd1: take = (a != b);
          3'd4: take = signed_lt(a, b);
          3'd5: take = !signed_lt(a, b);
          3'd6: take = (a < b);
          3'd7: take = (a >= b);
          default: bad = 1'b1;
        endcase
        if (take) nxt = pc + imm_b;
      end
      rv32i_pkg::OPC_LOAD: begin
        idx = int'((a + imm_i) % DataWords);
        w = shadow_mem[idx];
        writes = 1'b1;
        case (f3)
          3'd0: val = sign_ext({24'd0, w[7:0]}, 8);
          3'd1: val = sign_ext({16'd0, w[15:0]}, 16);
          3'd2: val = w;
          3'd4: val = {24'd0, w[7:0]};
          3'd5: val = {16'd0, w[15:0]};
          default: bad = 1'b1;
        endcase
      end
      rv32i_pkg::OPC_STORE: begin
        idx = int'((a + imm_s) % DataWords);
        w = shadow_mem[idx];
        case (f3)
          3'd0: shadow_mem[idx] = {w[31:8], b[7:0]};
          3'd1: shadow_mem[idx] = {w[31:16], b[15:0]};
          3'd2: shadow_mem[idx] = b;
          default: bad = 1'b1;
        endcase
      end
      default: bad = 1'b1;
    endcase
    if (bad) begin
      nxt = pc + 32'd4;
      writes = 1'b0;
    end
    if (rd == 5'd0) writes = 1'b0;
    if (writes) shadow_regs[rd] = val;
    r.next_pc = nxt;
    r.wr_en = writes;
    r.wr_idx = writes ? rd : 5'd0;
    r.wr_val = writes ? val : 32'd0;
    r.illegal = bad;
    return r;
  endfunction

  // Send one instruction item and record its expected result
  task automatic send_instruction(logic [31:0] ins, logic [31:0] pc);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {pc, ins};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_results.push_back(execute_instruction(ins, pc));
  endtask

  // Instruction builders
  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
    return {f7, rs2, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] op);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [6:0] op);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], op};
  endfunction

  // Mostly legal instructions with random fields, some raw noise
  function automatic logic [31:0] random_instruction();
    logic [6:0] opcodes [9];
    logic [31:0] ins;
    logic [6:0]  f7;
    opcodes = '{rv32i_pkg::OPC_OP, rv32i_pkg::OPC_OPIMM, rv32i_pkg::OPC_LUI,
                rv32i_pkg::OPC_AUIPC, rv32i_pkg::OPC_JAL, rv32i_pkg::OPC_JALR,
                rv32i_pkg::OPC_BRANCH, rv32i_pkg::OPC_LOAD, rv32i_pkg::OPC_STORE};
    ins = $urandom();
    if ($urandom_range(9) == 0) return ins;
    ins[6:0] = opcodes[$urandom_range(8)];
    if ($urandom_range(7) != 0) begin
      f7 = $urandom_range(1) ? rv32i_pkg::F7_ALT : rv32i_pkg::F7_ZERO;
      if (ins[6:0] == rv32i_pkg::OPC_OP || (ins[6:0] == rv32i_pkg::OPC_OPIMM &&
          (ins[14:12] == 3'd1 || ins[14:12] == 3'd5))) ins[31:25] = f7;
      if (ins[6:0] == rv32i_pkg::OPC_JALR) ins[14:12] = 3'd0;
      if (ins[6:0] == rv32i_pkg::OPC_LOAD && ins[14:12] == 3'd3) ins[14:12] = 3'd2;
      if (ins[6:0] == rv32i_pkg::OPC_STORE) ins[14:12] = 3'($urandom_range(2));
    end
    return ins;
  endfunction

  // Result checker
  always @(posedge clk) begin
    exec_result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[31:0], m_axis_tdata[32], m_axis_tdata[37:33],
             m_axis_tdata[69:38], m_axis_tuser};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch exp next_pc=%h en=%b idx=%0d val=%h ill=%b", $time,
                   want.next_pc, want.wr_en, want.wr_idx, want.wr_val, want.illegal);
          $display("%0t:          act next_pc=%h en=%b idx=%0d val=%h ill=%b", $time,
                   got.next_pc, got.wr_en, got.wr_idx, got.wr_val, got.illegal);
          fail_count++;
        end
      end
    end
  end

  // Receiver backpressure, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog on cycles with no item accepted and no result taken
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_count <= 0;
    else
      idle_count <= idle_count + 1;
    if (idle_count >= WatchdogLimit) begin
      $display("** rv32i_instruction_execute_unit: FAILED **");
      $finish;
    end
  end

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Directed: extremes, a selection of operations and the named special cases
  task automatic test_directed();
    send_instruction(enc_i(12'h7FF, 5'd0, 3'd0, 5'd1, rv32i_pkg::OPC_OPIMM), 32'd0);
    send_instruction(enc_i(12'h800, 5'd0, 3'd0, 5'd2, rv32i_pkg::OPC_OPIMM), 32'd4);
    send_instruction(enc_r(rv32i_pkg::F7_ALT, 5'd1, 5'd2, 3'd0, 5'd3, rv32i_pkg::OPC_OP),
                     32'd8);   // sub
    send_instruction(enc_r(rv32i_pkg::F7_ZERO, 5'd1, 5'd2, 3'd2, 5'd4, rv32i_pkg::OPC_OP),
                     32'd12);  // slt
    send_instruction(enc_r(rv32i_pkg::F7_ZERO, 5'd1, 5'd2, 3'd3, 5'd5, rv32i_pkg::OPC_OP),
                     32'd16);  // sltu
    send_instruction(enc_r(rv32i_pkg::F7_ALT, 5'd1, 5'd2, 3'd5, 5'd6, rv32i_pkg::OPC_OP),
                     32'd20);  // sra, 5-bit amount
    send_instruction(enc_i({rv32i_pkg::F7_ALT, 5'd31}, 5'd2, 3'd5, 5'd7,
                           rv32i_pkg::OPC_OPIMM), 32'd24); // srai
    send_instruction({20'hFFFFF, 5'd8, rv32i_pkg::OPC_LUI}, 32'd28);
    send_instruction({20'h80000, 5'd9, rv32i_pkg::OPC_AUIPC}, 32'hFFFF_FFF0);
    send_instruction(enc_s(12'hFFF, 5'd2, 5'd8, 3'd2, rv32i_pkg::OPC_STORE), 32'd32); // wrap
    send_instruction(enc_i(12'hFFF, 5'd8, 3'd0, 5'd10, rv32i_pkg::OPC_LOAD), 32'd36); // lb
    send_instruction(enc_i(12'hFFF, 5'd8, 3'd1, 5'd11, rv32i_pkg::OPC_LOAD), 32'd40); // lh
    send_instruction(enc_i(12'hFFF, 5'd8, 3'd4, 5'd12, rv32i_pkg::OPC_LOAD), 32'd44); // lbu
    send_instruction(enc_s(12'h001, 5'd1, 5'd0, 3'd0, rv32i_pkg::OPC_STORE), 32'd48); // sb
    send_instruction(enc_i(12'h001, 5'd0, 3'd5, 5'd13, rv32i_pkg::OPC_LOAD), 32'd52); // lhu
    send_instruction(enc_i(12'h003, 5'd1, 3'd0, 5'd14, rv32i_pkg::OPC_JALR), 32'd56); // odd
    send_instruction({1'b1, 10'h3FF, 1'b1, 8'hFF, 5'd15, rv32i_pkg::OPC_JAL}, 32'd60); // -2
    send_instruction({1'b1, 6'h3F, 5'd1, 5'd2, 3'd4, 4'hF, 1'b1, rv32i_pkg::OPC_BRANCH},
                     32'd64);  // blt
    send_instruction({1'b0, 6'h01, 5'd1, 5'd2, 3'd6, 4'h1, 1'b0, rv32i_pkg::OPC_BRANCH},
                     32'd68);  // bltu
    send_instruction({7'd0, 5'd1, 5'd2, 3'd2, 5'd0, rv32i_pkg::OPC_BRANCH}, 32'd72);
    send_instruction(enc_r(7'h01, 5'd1, 5'd2, 3'd0, 5'd16, rv32i_pkg::OPC_OP), 32'd76);
    send_instruction(enc_i(12'd0, 5'd1, 3'd3, 5'd17, rv32i_pkg::OPC_LOAD), 32'd80);
    send_instruction(enc_s(12'd0, 5'd1, 5'd1, 3'd3, rv32i_pkg::OPC_STORE), 32'd84);
    send_instruction(32'hFFFF_FFFF, 32'hFFFF_FFFC);                  // unknown opcode
    send_instruction(enc_i(12'h123, 5'd1, 3'd0, 5'd0, rv32i_pkg::OPC_OPIMM), 32'd88); // x0
    wait_drained();
  endtask

  // Random programs under one idling setting
  task automatic test_random(int n, int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < n; i++) send_instruction(random_instruction(), $urandom());
    wait_drained();
  endtask

  // Receiver holds off while the sender keeps offering items
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 60;
    for (int i = 0; i < 20; i++) send_instruction(random_instruction(), $urandom());
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    fail_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 0;
    idle_count = 0;
    for (int i = 0; i < 32; i++) shadow_regs[i] = '0;
    for (int i = 0; i < DataWords; i++) shadow_mem[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(200, 0, 0);
    test_random(200, 57, 0);
    test_random(200, 0, 57);
    test_random(200, 28, 28);
    test_backpressure();
    if (fail_count == 0) begin
      $display("** rv32i_instruction_execute_unit: PASSED **");
    end else begin
      $display("** rv32i_instruction_execute_unit: FAILED **");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/rv32i_pkg.sv
hdl/rv32i_regfile.sv
hdl/rv32i_dmem.sv
hdl/rv32i_instruction_execute_unit.sv
tb/tb_rv32i_instruction_execute_unit.sv
